// ===== design/nfcta_pkg.sv =====
// Shared types and constants for the Type A activation responder.
// Holds transaction structs, command codes, phase codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package nfcta_pkg;

	// Frame commands and PCBs recognized during activation
	localparam logic [7:0] CMD_HALT       = 8'h50;
	localparam logic [7:0] CMD_RATS       = 8'hE0;
	localparam logic [3:0] CMD_PPSS_HI    = 4'hD;
	localparam logic [7:0] PCB_DESEL_CID  = 8'hCA;
	localparam logic [7:0] PCB_DESEL_NONE = 8'hC2;
	localparam logic [7:0] PPS0_WITH_PPS1 = 8'h11;
	localparam logic [7:0] PPS0_NO_PPS1   = 8'h01;

	// Result actions
	localparam logic [1:0] ACT_WAIT = 2'd0;
	localparam logic [1:0] ACT_HALT = 2'd1;
	localparam logic [1:0] ACT_SEND = 2'd2;
	localparam logic [1:0] ACT_SW   = 2'd3;

	// Activation phases
	localparam logic [1:0] PH_L3  = 2'd0;
	localparam logic [1:0] PH_ATS = 2'd1;
	localparam logic [1:0] PH_L4  = 2'd2;

	// Configuration register indexes (byte address 4*index)
	localparam logic [1:0] REG_ATS_LENGTH    = 2'd0;
	localparam logic [1:0] REG_ATS_FORMAT    = 2'd1;
	localparam logic [1:0] REG_ATS_INTERFACE = 2'd2;

	localparam int ATS_MAX_BYTES = 5;
	localparam logic [2:0] ATS_MIN_LEN = 3'd2;
	localparam logic [2:0] ATS_MAX_LEN = 3'd5;
	localparam logic [3:0] FSDI_MAX    = 4'd12;
	localparam logic [3:0] CID_RFU     = 4'hF;

	typedef struct packed {
		logic        rx_error;
		logic [10:0] byte_count;
		logic [7:0]  first_byte;
		logic [7:0]  second_byte;
		logic [7:0]  third_byte;
		logic [3:0]  silent_slots;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  reply_length;
		logic [39:0] reply_data;
		logic [3:0]  reply_silent;
		logic        reply_to_halt;
		logic [1:0]  tx_rate_code;
		logic [1:0]  rx_rate_code;
		logic        ignore_reqa;
		logic        layer4_on;
		logic [7:0]  rats_param;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  ats_length;
		logic [7:0]  ats_format;
		logic [23:0] ats_interface;
	} cfg_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [3:0] card_cid;
		logic [3:0] frame_limit_index;
		logic [1:0] tx_rate;
		logic [1:0] rx_rate;
	} card_state_t;

endpackage

// ===== design/nfcta_decide.sv =====
// Frame decision logic: maps one received frame summary and the card state
// to one result transaction and the next card state. Depends on nfcta_pkg.
`timescale 1ns / 1ps

module nfcta_decide import nfcta_pkg::*; (
	input  cfg_t        cfg,
	input  card_state_t st,
	input  in_item_t    item,
	output out_item_t   result,
	output card_state_t nxt
);

	logic [2:0]  ats_n;
	logic [39:0] ats_full;
	logic [39:0] ats_data;
	logic        size_ok;
	logic        rats_ok;
	logic        is_pps;
	logic        do_l4;

	// Clamp ATS length and assemble the ATS bytes, masking unsent ones
	always_comb begin
		if (cfg.ats_length < ATS_MIN_LEN) begin
			ats_n = ATS_MIN_LEN;
		end else if (cfg.ats_length > ATS_MAX_LEN) begin
			ats_n = ATS_MAX_LEN;
		end else begin
			ats_n = cfg.ats_length;
		end
		ats_full = {cfg.ats_interface, cfg.ats_format, 5'd0, ats_n};
		for (int i = 0; i < ATS_MAX_BYTES; i++) begin
			ats_data[8*i +: 8] = (3'(i) < ats_n) ? ats_full[8*i +: 8] : 8'd0;
		end
	end

	assign size_ok = !item.rx_error && (item.byte_count >= 11'd4);
	assign rats_ok = (item.first_byte == CMD_RATS) && (item.byte_count == 11'd4)
		&& (item.second_byte[3:0] != CID_RFU) && (item.second_byte[7:4] <= FSDI_MAX);
	assign is_pps  = (item.first_byte[7:4] == CMD_PPSS_HI);
	// Layer 4 handling applies in phase 2, or in phase 1 for a good non-PPS frame
	assign do_l4   = (st.phase != PH_L3 && st.phase != PH_ATS)
		|| (st.phase == PH_ATS && size_ok && !is_pps);

	// Decide the action and the next state
	always_comb begin
		result = '0;
		nxt    = st;
		case (st.phase)
			PH_L3: begin
				result.action = ACT_HALT;
				if (size_ok) begin
					if (item.first_byte == CMD_HALT && item.second_byte == 8'd0
							&& item.byte_count == 11'd4) begin
						result.ignore_reqa = 1'b1;
					end else if (rats_ok) begin
						result.action            = ACT_SEND;
						result.reply_length      = ats_n;
						result.reply_data        = ats_data;
						result.ignore_reqa       = 1'b1;
						result.rats_param        = item.second_byte;
						nxt.card_cid             = item.second_byte[3:0];
						nxt.frame_limit_index    = item.second_byte[7:4];
						nxt.phase                = PH_ATS;
					end
				end
			end
			PH_ATS: begin
				result.action = ACT_WAIT;
				if (size_ok && is_pps) begin
					if (item.first_byte[3:0] == st.card_cid) begin
						if (item.second_byte == PPS0_NO_PPS1 && item.byte_count == 11'd4) begin
							result.action       = ACT_SEND;
							result.reply_length = 3'd1;
							result.reply_data   = {32'd0, CMD_PPSS_HI, st.card_cid};
							nxt.phase           = PH_L4;
						end else if (item.second_byte == PPS0_WITH_PPS1
								&& item.byte_count == 11'd5 && item.third_byte[7:4] == 4'd0) begin
							result.action       = ACT_SEND;
							result.reply_length = 3'd1;
							result.reply_data   = {32'd0, CMD_PPSS_HI, st.card_cid};
							nxt.rx_rate         = item.third_byte[1:0];
							nxt.tx_rate         = item.third_byte[3:2];
							nxt.phase           = PH_L4;
						end
					end
				end else if (size_ok) begin
					nxt.phase = PH_L4;
				end
			end
			default: begin
				result.action = ACT_WAIT;
			end
		endcase

		// Layer 4: DESELECT acknowledge, mute on errors and bad DESELECT frames, or forward to software
		if (do_l4) begin
			if (item.rx_error) begin
				result.action = ACT_WAIT;
			end else if (item.first_byte == PCB_DESEL_CID) begin
				if (item.second_byte == {4'd0, st.card_cid} && item.byte_count == 11'd4) begin
					result.action        = ACT_SEND;
					result.reply_length  = 3'd2;
					result.reply_data    = {24'd0, 4'd0, st.card_cid, PCB_DESEL_CID};
					result.reply_to_halt = 1'b1;
					nxt.tx_rate          = 2'd0;
					nxt.rx_rate          = 2'd0;
					nxt.phase            = PH_L3;
				end else begin
					result.action = ACT_WAIT;
				end
			end else if (item.first_byte == PCB_DESEL_NONE) begin
				if (item.byte_count == 11'd3) begin
					result.action        = ACT_SEND;
					result.reply_length  = 3'd1;
					result.reply_data    = {32'd0, PCB_DESEL_NONE};
					result.reply_to_halt = 1'b1;
					nxt.tx_rate          = 2'd0;
					nxt.rx_rate          = 2'd0;
					nxt.phase            = PH_L3;
				end else begin
					result.action = ACT_WAIT;
				end
			end else begin
				result.action = ACT_SW;
			end
		end

		// Status that follows the state after this frame
		result.reply_silent = (result.action == ACT_SEND) ? item.silent_slots : 4'd0;
		result.tx_rate_code = nxt.tx_rate;
		result.rx_rate_code = nxt.rx_rate;
		result.layer4_on    = (nxt.phase != PH_L3);
	end

endmodule

// ===== design/nfc_typea_activation_responder.sv =====
// A frame accepted into the input register is decided combinationally and its
// result is loaded into the result register. Throughput: one frame per cycle while
// out_ready is high; a stalled result register still admits one more input frame.
// Reset: arst_n clears phase 0, CID 0, both rates 106 kbit/s, ATS length 2,
// format and interface bytes 0, and empties both registers.
// Depends on nfcta_pkg and nfcta_decide.
`timescale 1ns / 1ps

module nfc_typea_activation_responder import nfcta_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t        cfg_q;
	card_state_t st_q;
	card_state_t st_nxt;
	logic        valid_s1;
	in_item_t    item_s1;
	logic        valid_s2;
	out_item_t   result_s2;
	out_item_t   result;
	logic        advance;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ats_length    <= ATS_MIN_LEN;
			cfg_q.ats_format    <= 8'd0;
			cfg_q.ats_interface <= 24'd0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ATS_LENGTH:    cfg_q.ats_length    <= pwdata[2:0];
				REG_ATS_FORMAT:    cfg_q.ats_format    <= pwdata[7:0];
				REG_ATS_INTERFACE: cfg_q.ats_interface <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (paddr[3:2])
			REG_ATS_LENGTH:    prdata = {29'd0, cfg_q.ats_length};
			REG_ATS_FORMAT:    prdata = {24'd0, cfg_q.ats_format};
			REG_ATS_INTERFACE: prdata = {8'd0, cfg_q.ats_interface};
			default:           prdata = 32'd0;
		endcase
	end

	// Move a frame from the input register to the result register when free
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	nfcta_decide u_decide (
		.cfg    (cfg_q),
		.st     (st_q),
		.item   (item_s1),
		.result (result),
		.nxt    (st_nxt)
	);

	// Hold control state: stage valids and card state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				st_q     <= st_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Load payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	// Phase 3 is never entered
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase != 2'd3)
		else $error("card phase reached unused code");

	// Only an FSDI that passed the RATS check is stored
	a_fsdi_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.frame_limit_index <= FSDI_MAX)
		else $error("stored frame limit index out of range");

	// With layer 4 off both rates are back at 106 kbit/s
	a_rates_l3: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.layer4_on) |->
			(out_data.tx_rate_code == 2'd0 && out_data.rx_rate_code == 2'd0))
		else $error("non-default rate while layer 4 is off");

	// A muted or forwarded frame carries no reply
	a_no_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.action != ACT_SEND) |->
			(out_data.reply_length == 3'd0 && out_data.reply_silent == 4'd0
				&& out_data.reply_to_halt == 1'b0))
		else $error("reply fields set without a send action");

	// Input stalls only when both registers are full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input stalled with room in the pipeline");

endmodule

// ===== test/nfc_typea_activation_responder_test.sv =====
// Self-checking testbench for the Type A activation responder.
// Predicts every answer from its own model of phases, CID and rates.
// Depends on nfcta_pkg and nfc_typea_activation_responder.
`timescale 1ns / 1ps

module nfc_typea_activation_responder_test;
	import nfcta_pkg::*;

	localparam int CYCLE_LIMIT      = 200000;
	localparam int SETTLE_CYCLES    = 6;
	localparam int RANDOM_PER_PASS  = 362;
	localparam int STALL_FRAMES     = 40;
	localparam int STALL_CYCLES     = 300;
	localparam int MAX_REPORTS      = 30;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [3:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	nfc_typea_activation_responder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Card model: activation state and ATS registers
	logic [1:0]  card_phase   = PH_L3;
	logic [3:0]  card_cid     = '0;
	logic [3:0]  card_fsdi    = '0;
	logic [1:0]  card_tx_rate = '0;
	logic [1:0]  card_rx_rate = '0;
	logic [2:0]  cfg_tl       = ATS_MIN_LEN;
	logic [7:0]  cfg_t0       = '0;
	logic [23:0] cfg_tabc     = '0;

	out_item_t pending_answers[$];
	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;
	int stall_request     = 0;
	int stall_left        = 0;
	int cycle_count       = 0;
	int mismatch_count    = 0;
	int frames_sent       = 0;
	int answers_checked   = 0;
	int action_seen[4]    = '{default: 0};

	always #2 clk = ~clk;

	// Work out the card's answer to one frame and advance the card state
	function automatic out_item_t predict_answer(input in_item_t f);
		out_item_t   r;
		logic [2:0]  tl;
		logic [39:0] ats;
		int          k;
		r = '0;
		if (card_phase == PH_L3) begin
			r.action = ACT_HALT;
			if (!f.rx_error && f.byte_count >= 11'd4) begin
				if (f.first_byte == CMD_HALT && f.second_byte == 8'h00 &&
				    f.byte_count == 11'd4) begin
					r.ignore_reqa = 1'b1;
				end else if (f.first_byte == CMD_RATS && f.byte_count == 11'd4 &&
				             f.second_byte[3:0] != CID_RFU &&
				             f.second_byte[7:4] <= FSDI_MAX) begin
					// Clamp TL and drop the bytes beyond it
					tl = (cfg_tl < ATS_MIN_LEN) ? ATS_MIN_LEN :
					     (cfg_tl > ATS_MAX_LEN) ? ATS_MAX_LEN : cfg_tl;
					ats = {cfg_tabc, cfg_t0, 5'd0, tl};
					for (k = 0; k < ATS_MAX_BYTES; k++)
						if (k >= tl) ats[8*k +: 8] = 8'h00;
					r.action       = ACT_SEND;
					r.reply_length = tl;
					r.reply_data   = ats;
					r.ignore_reqa  = 1'b1;
					r.rats_param   = f.second_byte;
					card_cid       = f.second_byte[3:0];
					card_fsdi      = f.second_byte[7:4];
					card_phase     = PH_ATS;
				end
			end
		end else if (card_phase == PH_ATS && (f.rx_error || f.byte_count < 11'd4 ||
		             f.first_byte[7:4] == CMD_PPSS_HI)) begin
			// PPS window: anything wrong mutes and keeps the window open
			r.action = ACT_WAIT;
			if (!f.rx_error && f.byte_count >= 11'd4 && f.first_byte[3:0] == card_cid) begin
				if (f.second_byte == PPS0_NO_PPS1 && f.byte_count == 11'd4) begin
					r.action = ACT_SEND;
				end else if (f.second_byte == PPS0_WITH_PPS1 && f.byte_count == 11'd5 &&
				             f.third_byte[7:4] == 4'h0) begin
					card_rx_rate = f.third_byte[1:0];
					card_tx_rate = f.third_byte[3:2];
					r.action = ACT_SEND;
				end
				if (r.action == ACT_SEND) begin
					r.reply_length = 3'd1;
					r.reply_data   = {32'd0, CMD_PPSS_HI, card_cid};
					card_phase     = PH_L4;
				end
			end
		end else begin
			// Protocol active: only DESELECT is handled here
			card_phase = PH_L4;
			if (!f.rx_error) begin
				if (f.first_byte == PCB_DESEL_CID) begin
					if (f.second_byte == {4'h0, card_cid} && f.byte_count == 11'd4) begin
						r.action       = ACT_SEND;
						r.reply_length = 3'd2;
						r.reply_data   = {28'd0, card_cid, PCB_DESEL_CID};
					end
				end else if (f.first_byte == PCB_DESEL_NONE) begin
					if (f.byte_count == 11'd3) begin
						r.action       = ACT_SEND;
						r.reply_length = 3'd1;
						r.reply_data   = {32'd0, PCB_DESEL_NONE};
					end
				end else begin
					r.action = ACT_SW;
				end
			end
			if (r.action == ACT_SEND) begin
				r.reply_to_halt = 1'b1;
				card_tx_rate    = 2'd0;
				card_rx_rate    = 2'd0;
				card_phase      = PH_L3;
			end
		end
		r.reply_silent = (r.action == ACT_SEND) ? f.silent_slots : 4'd0;
		r.tx_rate_code = card_tx_rate;
		r.rx_rate_code = card_rx_rate;
		r.layer4_on    = (card_phase != PH_L3);
		return r;
	endfunction

	function automatic in_item_t build_frame(input logic err, input logic [10:0] size,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
			input logic [3:0] slots);
		in_item_t f;
		f = '{err, size, b0, b1, b2, slots};
		return f;
	endfunction

	// Shape a layer 4 block: half DESELECT, the rest random blocks for software
	function automatic in_item_t shape_block(input in_item_t f);
		int pick;
		pick = $urandom_range(3);
		if (pick == 0) begin
			f.first_byte = PCB_DESEL_CID;
			if ($urandom_range(9) != 0) f.second_byte = {4'h0, card_cid};
			if ($urandom_range(9) != 0) f.byte_count = 11'd4;
		end else if (pick == 1) begin
			f.first_byte = PCB_DESEL_NONE;
			if ($urandom_range(9) != 0) f.byte_count = 11'd3;
		end else begin
			f.byte_count = 11'($urandom_range(64, 3));
		end
		return f;
	endfunction

	// Pick a frame that fits the card's phase, with some noise and damage mixed in
	function automatic in_item_t pick_frame();
		in_item_t f;
		int       roll;
		f.rx_error     = ($urandom_range(99) < 5);
		f.byte_count   = ($urandom_range(19) == 0) ? 11'($urandom_range(2047)) :
		                                              11'($urandom_range(8));
		f.first_byte   = 8'($urandom_range(255));
		f.second_byte  = 8'($urandom_range(255));
		f.third_byte   = 8'($urandom_range(255));
		f.silent_slots = 4'($urandom_range(15));
		roll = $urandom_range(99);
		if (roll < 15) return f;
		case (card_phase)
			PH_L3: begin
				if ($urandom_range(9) != 0) f.byte_count = 11'd4;
				if (roll < 35) begin
					f.first_byte = CMD_HALT;
					if ($urandom_range(3) != 0) f.second_byte = 8'h00;
				end else begin
					f.first_byte = CMD_RATS;
					if ($urandom_range(9) != 0)
						f.second_byte = {4'($urandom_range(12)), 4'($urandom_range(14))};
				end
			end
			PH_ATS: begin
				if (roll < 80) begin
					f.first_byte = {CMD_PPSS_HI,
					                ($urandom_range(9) == 0) ? f.first_byte[3:0] : card_cid};
					if ($urandom_range(1) == 0) begin
						f.second_byte = PPS0_NO_PPS1;
						if ($urandom_range(9) != 0) f.byte_count = 11'd4;
					end else begin
						f.second_byte = PPS0_WITH_PPS1;
						if ($urandom_range(9) != 0) f.byte_count = 11'd5;
						if ($urandom_range(9) != 0) f.third_byte[7:4] = 4'h0;
					end
				end else begin
					f = shape_block(f);
				end
			end
			default: f = shape_block(f);
		endcase
		return f;
	endfunction

	// Offer one frame transaction and record the expected answer on acceptance
	task automatic send_frame(input in_item_t f);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= f;
		do @(posedge clk); while (!in_ready);
		pending_answers.push_back(predict_answer(f));
		action_seen[pending_answers[$].action]++;
		frames_sent++;
	endtask

	// Drop valid and hold until every expected answer has come back
	task automatic wait_answers_done();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup and access cycle; psel stays up for back-to-back writes
	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_ATS_LENGTH:    cfg_tl   = value[2:0];
			REG_ATS_FORMAT:    cfg_t0   = value[7:0];
			REG_ATS_INTERFACE: cfg_tabc = value[23:0];
			default: ;
		endcase
	endtask

	task automatic configure_ats(input logic [2:0] tl, input logic [7:0] t0,
			input logic [23:0] tabc);
		apb_write(REG_ATS_LENGTH, 32'(tl));
		apb_write(REG_ATS_FORMAT, 32'(t0));
		apb_write(REG_ATS_INTERFACE, 32'(tabc));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Walk through HALT, RATS, PPS and DESELECT, good and broken
	task automatic test_activation_directed();
		sender_idle_pct   = 30;
		receiver_idle_pct = 30;
		send_frame(build_frame(1'b0, 11'd4, CMD_HALT, 8'h00, 8'h00, 4'h0));
		send_frame(build_frame(1'b1, 11'd4, CMD_HALT, 8'h00, 8'h00, 4'hF));
		send_frame(build_frame(1'b0, 11'd3, CMD_RATS, 8'h50, 8'h00, 4'h7));
		send_frame(build_frame(1'b0, 11'd4, CMD_RATS, {FSDI_MAX, CID_RFU}, 8'h00, 4'h1));
		send_frame(build_frame(1'b0, 11'd4, CMD_RATS, {4'd13, 4'd1}, 8'h00, 4'h2));
		send_frame(build_frame(1'b0, 11'd0, 8'hFF, 8'hFF, 8'hFF, 4'h0));
		send_frame(build_frame(1'b0, 11'd4, CMD_RATS, {FSDI_MAX, 4'hE}, 8'hFF, 4'hF));
		send_frame(build_frame(1'b0, 11'd4, {CMD_PPSS_HI, 4'h1}, PPS0_NO_PPS1, 8'h00, 4'h3));
		send_frame(build_frame(1'b0, 11'd4, {CMD_PPSS_HI, 4'hE}, PPS0_WITH_PPS1, 8'h00, 4'h3));
		send_frame(build_frame(1'b0, 11'd5, {CMD_PPSS_HI, 4'hE}, PPS0_WITH_PPS1, 8'h10, 4'h3));
		send_frame(build_frame(1'b1, 11'd5, {CMD_PPSS_HI, 4'hE}, PPS0_WITH_PPS1, 8'h0F, 4'h3));
		send_frame(build_frame(1'b0, 11'd5, {CMD_PPSS_HI, 4'hE}, PPS0_WITH_PPS1, 8'h0F, 4'hF));
		send_frame(build_frame(1'b0, 11'd1024, 8'h02, 8'h00, 8'h00, 4'h0));
		send_frame(build_frame(1'b0, 11'd4, PCB_DESEL_CID, 8'h0D, 8'h00, 4'h4));
		send_frame(build_frame(1'b0, 11'd5, PCB_DESEL_CID, 8'h0E, 8'h00, 4'h4));
		send_frame(build_frame(1'b1, 11'd3, PCB_DESEL_NONE, 8'h00, 8'h00, 4'h4));
		send_frame(build_frame(1'b0, 11'd4, PCB_DESEL_CID, 8'h0E, 8'h00, 4'hF));
		send_frame(build_frame(1'b0, 11'd4, CMD_RATS, 8'h00, 8'h00, 4'h0));
		// A non-PPS frame closes the PPS window and is handled as layer 4
		send_frame(build_frame(1'b0, 11'd2047, 8'h03, 8'hFF, 8'hFF, 4'hF));
		send_frame(build_frame(1'b0, 11'd4, PCB_DESEL_NONE, 8'h00, 8'h00, 4'h6));
		send_frame(build_frame(1'b0, 11'd3, PCB_DESEL_NONE, 8'h00, 8'h00, 4'h9));
		send_frame(build_frame(1'b0, 11'd4, CMD_RATS, 8'h81, 8'h00, 4'h5));
		send_frame(build_frame(1'b0, 11'd4, {CMD_PPSS_HI, 4'h1}, PPS0_NO_PPS1, 8'hFF, 4'h5));
		send_frame(build_frame(1'b0, 11'd4, PCB_DESEL_CID, 8'h01, 8'h00, 4'hA));
		wait_answers_done();
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
		sender_idle_pct   = send_pct;
		receiver_idle_pct = recv_pct;
		repeat (count) send_frame(pick_frame());
		wait_answers_done();
	endtask

	// Hold the output for a long stretch while frames keep coming
	task automatic test_output_stall();
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		stall_request     = STALL_CYCLES;
		repeat (STALL_FRAMES) send_frame(pick_frame());
		wait_answers_done();
	endtask

	// Drive out_ready: random idling, or a counted hold-off when requested
	always @(posedge clk) begin
		if (stall_request > 0) begin
			stall_left    = stall_request;
			stall_request = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	task automatic compare_field(input string name, input logic [39:0] want,
			input logic [39:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				         $time, name, want, got);
		end
	endtask

	// Check each answer transaction against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected answer, expected none, actual 0x%0h",
					         $time, out_data);
			end else begin
				want = pending_answers.pop_front();
				compare_field("action", 40'(want.action), 40'(out_data.action));
				compare_field("reply_length", 40'(want.reply_length),
				              40'(out_data.reply_length));
				compare_field("reply_data", want.reply_data, out_data.reply_data);
				compare_field("reply_silent", 40'(want.reply_silent),
				              40'(out_data.reply_silent));
				compare_field("reply_to_halt", 40'(want.reply_to_halt),
				              40'(out_data.reply_to_halt));
				compare_field("tx_rate_code", 40'(want.tx_rate_code),
				              40'(out_data.tx_rate_code));
				compare_field("rx_rate_code", 40'(want.rx_rate_code),
				              40'(out_data.rx_rate_code));
				compare_field("ignore_reqa", 40'(want.ignore_reqa),
				              40'(out_data.ignore_reqa));
				compare_field("layer4_on", 40'(want.layer4_on), 40'(out_data.layer4_on));
				compare_field("rats_param", 40'(want.rats_param), 40'(out_data.rats_param));
				answers_checked++;
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d answers outstanding",
			         cycle_count, pending_answers.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_activation_directed();
		configure_ats(3'd0, 8'hFF, 24'hFFFFFF);
		test_random_traffic(11, 77, RANDOM_PER_PASS);
		configure_ats(3'd7, 8'h00, 24'h000000);
		test_random_traffic(77, 11, RANDOM_PER_PASS);
		configure_ats(ATS_MAX_LEN, 8'($urandom_range(255)), 24'($urandom_range(24'hFFFFFF)));
		test_random_traffic(0, 0, RANDOM_PER_PASS);
		configure_ats(3'd3, 8'($urandom_range(255)), 24'($urandom_range(24'hFFFFFF)));
		test_output_stall();
		$display("Checked %0d answers to %0d frames: %0d muted, %0d halted,",
		         answers_checked, frames_sent, action_seen[ACT_WAIT], action_seen[ACT_HALT]);
		$display("%0d replies, %0d to software; ATS lengths 2, 3, 5 and clamped from 0 and 7",
		         action_seen[ACT_SEND], action_seen[ACT_SW]);
		$display("%0d field mismatches", mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
